// ----- design/dwpd_pkg.sv -----
// Package with the constants, result kinds and handshake text of the debug wire packet deframer.
package dwpd_pkg;

    // Handshake and header sizes, in bytes.
    localparam int HS_BYTES  = 14;
    localparam int HDR_BYTES = 11;

    // Widths of the counters and of the packed result.
    localparam int IDX_W       = 4;
    localparam int LEN_W       = 32;
    localparam int KIND_W      = 3;
    localparam int OUT_DATA_W  = 112;
    localparam int OUT_USED_W  = 105;

    // Result kinds, carried on tuser.
    typedef logic [KIND_W-1:0] kind_t;
    localparam kind_t KIND_HS_DONE = 3'd0;
    localparam kind_t KIND_HEADER  = 3'd1;
    localparam kind_t KIND_PAYLOAD = 3'd2;
    localparam kind_t KIND_HS_BAD  = 3'd3;
    localparam kind_t KIND_BAD_LEN = 3'd4;

    // Expected handshake character at a position; positions past the text expect zero.
    function automatic logic [7:0] hs_char(input logic [IDX_W-1:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = 8'h4A; // J
            4'd1:    c = 8'h44; // D
            4'd2:    c = 8'h57; // W
            4'd3:    c = 8'h50; // P
            4'd4:    c = 8'h2D; // -
            4'd5:    c = 8'h48; // H
            4'd6:    c = 8'h61; // a
            4'd7:    c = 8'h6E; // n
            4'd8:    c = 8'h64; // d
            4'd9:    c = 8'h73; // s
            4'd10:   c = 8'h68; // h
            4'd11:   c = 8'h61; // a
            4'd12:   c = 8'h6B; // k
            4'd13:   c = 8'h65; // e
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- design/debug_wire_packet_deframer.sv -----
// Top level of the debug wire packet deframer: handshake matcher and packet header parser.
//
//  Channel  Dir  tdata (low bit up)                                     tuser  tlast
//  s_       in   rx_byte[7:0]                                           -      -
//  m_       out  packet_id, is_reply, command_set, command_code,        kind   last
//                error_code, payload_length, data_byte, zero fill
//
// Each byte is taken into the input register and parsed on its way into the result
// register, so one byte per cycle is taken while the result register is free; a result
// shows on m_tvalid once its last byte has passed both registers. Reset clears the
// phase, the handshake and header indices and both valid flags. A stalled result holds
// the parser; the input register still takes one more beat before s_tready falls.
module debug_wire_packet_deframer
    import dwpd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // rx_byte[7:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // packet_id[31:0], is_reply[32], command_set[40:33], command_code[48:41],
    // error_code[64:49], payload_length[96:65], data_byte[104:97], zero[111:105]
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [KIND_W-1:0]     m_tuser,   // kind[2:0]
    output logic                  m_tlast    // last
);

    typedef enum logic [1:0] {
        PH_HANDSHAKE = 2'd0,
        PH_HEADER    = 2'd1,
        PH_PAYLOAD   = 2'd2
    } phase_t;

    localparam logic [IDX_W:0]   HS_LAST  = (IDX_W+1)'(HS_BYTES);
    localparam logic [IDX_W:0]   HDR_LAST = (IDX_W+1)'(HDR_BYTES);
    localparam logic [LEN_W-1:0] HDR_LEN  = LEN_W'(HDR_BYTES);

    // Input register.
    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_byte_reg;

    // Parser state.
    phase_t           phase_reg, phase_next;
    logic [IDX_W-1:0] match_idx_reg, match_idx_next;
    logic [IDX_W-1:0] hdr_idx_reg, hdr_idx_next;
    logic [LEN_W-1:0] total_len_reg, total_len_next;
    logic [31:0]      id_reg, id_next;
    logic [7:0]       flag_reg, flag_next;
    logic [7:0]       set_reg, set_next;
    logic [LEN_W-1:0] left_reg, left_next;

    // Result register.
    logic             out_valid_reg, out_valid_next;
    kind_t            out_kind_reg, out_kind_next;
    logic [31:0]      out_id_reg, out_id_next;
    logic             out_reply_reg, out_reply_next;
    logic [7:0]       out_set_reg, out_set_next;
    logic [7:0]       out_cmd_reg, out_cmd_next;
    logic [15:0]      out_err_reg, out_err_next;
    logic [LEN_W-1:0] out_plen_reg, out_plen_next;
    logic [7:0]       out_data_reg, out_data_next;
    logic             out_last_reg, out_last_next;

    logic             out_free;
    logic             work;
    logic [IDX_W:0]   match_inc;
    logic [IDX_W:0]   hdr_inc;
    logic [LEN_W-1:0] left_dec;
    logic [LEN_W-1:0] plen;

    // The result register frees when it is empty or its beat is taken.
    assign out_free = !out_valid_reg || m_tready;
    assign work     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    assign match_inc = {1'b0, match_idx_reg} + 1'b1;
    assign hdr_inc   = {1'b0, hdr_idx_reg} + 1'b1;
    assign left_dec  = left_reg - 1'b1;
    assign plen      = total_len_reg - HDR_LEN;

    // Input register moves on when it is empty or its byte is parsed.
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (work) begin
            in_valid_next = 1'b0;
        end
    end

    // Parse the byte in the input register and build its result.
    always_comb begin
        phase_next     = phase_reg;
        match_idx_next = match_idx_reg;
        hdr_idx_next   = hdr_idx_reg;
        total_len_next = total_len_reg;
        id_next        = id_reg;
        flag_next      = flag_reg;
        set_next       = set_reg;
        left_next      = left_reg;

        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_id_next    = out_id_reg;
        out_reply_next = out_reply_reg;
        out_set_next   = out_set_reg;
        out_cmd_next   = out_cmd_reg;
        out_err_next   = out_err_reg;
        out_plen_next  = out_plen_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        if (work) begin
            // Fields that mean nothing for a kind are zero.
            out_valid_next = 1'b0;
            out_kind_next  = KIND_HS_DONE;
            out_id_next    = '0;
            out_reply_next = 1'b0;
            out_set_next   = '0;
            out_cmd_next   = '0;
            out_err_next   = '0;
            out_plen_next  = '0;
            out_data_next  = '0;
            out_last_next  = 1'b0;

            unique case (phase_reg)
                PH_HANDSHAKE: begin
                    if (in_byte_reg == hs_char(match_idx_reg)) begin
                        if (match_inc >= HS_LAST) begin
                            match_idx_next = '0;
                            hdr_idx_next   = '0;
                            phase_next     = PH_HEADER;
                            out_valid_next = 1'b1;
                            out_kind_next  = KIND_HS_DONE;
                        end else begin
                            match_idx_next = match_inc[IDX_W-1:0];
                        end
                    end else begin
                        match_idx_next = '0;
                        out_valid_next = 1'b1;
                        out_kind_next  = KIND_HS_BAD;
                    end
                end
                PH_PAYLOAD: begin
                    left_next      = left_dec;
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_PAYLOAD;
                    out_data_next  = in_byte_reg;
                    if (left_dec == '0) begin
                        out_last_next = 1'b1;
                        phase_next    = PH_HEADER;
                        hdr_idx_next  = '0;
                    end
                end
                default: begin
                    // Header phase; the unused phase code behaves the same.
                    phase_next = PH_HEADER;
                    if (hdr_idx_reg < 4'd4) begin
                        total_len_next = {total_len_reg[LEN_W-9:0], in_byte_reg};
                    end else if (hdr_idx_reg < 4'd8) begin
                        id_next = {id_reg[23:0], in_byte_reg};
                    end else if (hdr_idx_reg == 4'd8) begin
                        flag_next = in_byte_reg;
                    end else if (hdr_idx_reg == 4'd9) begin
                        set_next = in_byte_reg;
                    end

                    if (hdr_inc < HDR_LAST) begin
                        hdr_idx_next = hdr_inc[IDX_W-1:0];
                    end else begin
                        hdr_idx_next   = '0;
                        out_valid_next = 1'b1;
                        if (total_len_reg < HDR_LEN) begin
                            out_kind_next = KIND_BAD_LEN;
                        end else begin
                            out_kind_next  = KIND_HEADER;
                            out_id_next    = id_reg;
                            out_reply_next = (flag_reg != 8'd0);
                            out_set_next   = set_reg;
                            out_cmd_next   = in_byte_reg;
                            out_err_next   = {set_reg, in_byte_reg};
                            out_plen_next  = plen;
                            left_next      = plen;
                            if (plen == '0) begin
                                out_last_next = 1'b1;
                            end else begin
                                phase_next = PH_PAYLOAD;
                            end
                        end
                    end
                end
            endcase
        end
    end

    // Control state and valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_HANDSHAKE;
            match_idx_reg <= '0;
            hdr_idx_reg   <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            match_idx_reg <= match_idx_next;
            hdr_idx_reg   <= hdr_idx_next;
        end
    end

    // Payload registers: input byte, header shift registers and the result.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        total_len_reg <= total_len_next;
        id_reg        <= id_next;
        flag_reg      <= flag_next;
        set_reg       <= set_next;
        left_reg      <= left_next;
        out_kind_reg  <= out_kind_next;
        out_id_reg    <= out_id_next;
        out_reply_reg <= out_reply_next;
        out_set_reg   <= out_set_next;
        out_cmd_reg   <= out_cmd_next;
        out_err_reg   <= out_err_next;
        out_plen_reg  <= out_plen_next;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
    end

    // Result beat.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(OUT_DATA_W-OUT_USED_W){1'b0}}, out_data_reg, out_plen_reg,
                       out_err_reg, out_cmd_reg, out_set_reg, out_reply_reg, out_id_reg};

endmodule
